FILE: design/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOW  = 2'd0,
    CFG_MID  = 2'd1,
    CFG_HIGH = 2'd2
  } cfg_idx_e;

  localparam int unsigned CalW     = 168;  // 21 calibration bytes
  localparam int unsigned CfgW     = 64;
  localparam int unsigned CalHighW = 40;

  // multiplier digit width and pipeline depth
  localparam int unsigned ChunkW = 32;
  localparam int unsigned MulLat = 5;

  // temperature scaled by 2^48
  localparam int unsigned TnW = 61;

  // pipeline depths: stages up to the tn register, and stages of the pressure part
  localparam int unsigned TnLat    = 4;
  localparam int unsigned PressLat = 25;
  localparam int unsigned TotalLat = TnLat + PressLat;

  localparam logic signed [23:0] TempMax  = 24'sh7fffff;
  localparam logic signed [23:0] TempMin  = -24'sh800000;
  localparam logic [25:0]        PressMax = 26'h3ffffff;

  typedef struct packed {
    logic [23:0]        t1;
    logic [15:0]        t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coef_t;

  // split the calibration bytes into coefficients
  function automatic coef_t bpc_decode(input logic [CalW-1:0] cb);
    coef_t c;
    c.t1  = {cb[15:8], cb[7:0], 8'h00};
    c.t2  = {cb[31:24], cb[23:16]};
    c.t3  = cb[39:32];
    c.p1  = 17'($signed({cb[55:48], cb[47:40]})) - 17'sd16384;
    c.p2  = 17'($signed({cb[71:64], cb[63:56]})) - 17'sd16384;
    c.p3  = cb[79:72];
    c.p4  = cb[87:80];
    c.p5  = {cb[103:96], cb[95:88]};
    c.p6  = {cb[119:112], cb[111:104]};
    c.p7  = cb[127:120];
    c.p8  = cb[135:128];
    c.p9  = {cb[151:144], cb[143:136]};
    c.p10 = cb[159:152];
    c.p11 = cb[167:160];
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/bpc_delay.sv
`default_nettype none

module bpc_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [D];

  // payload shift line, no reset needed
  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int i = 1; i < int'(D); i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[D-1];

endmodule

`default_nettype wire

FILE: design/bpc_mul.sv
`default_nettype none

// signed multiplier, five register stages, wide operand a, b up to two digits
module bpc_mul #(
  parameter int unsigned WA = 61,
  parameter int unsigned WB = 8
) (
  input  logic                 clk_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import bpc_pkg::*;

  localparam int unsigned NA   = (WA + ChunkW - 1) / ChunkW;
  localparam int unsigned NAE  = NA + (NA % 2);
  localparam int unsigned NB   = (WB + ChunkW - 1) / ChunkW;
  localparam int unsigned AW   = NAE * ChunkW;
  localparam int unsigned BW   = NB * ChunkW;
  localparam int unsigned RowW = AW + ChunkW;
  localparam int unsigned SumW = AW + BW;
  localparam int unsigned PW   = WA + WB;

  logic [WA-1:0]       a_abs;
  logic [WB-1:0]       b_abs;
  logic [AW-1:0]       amag_q;
  logic [BW-1:0]       bmag_q;
  logic [3:0]          neg_q;
  logic [2*ChunkW-1:0] pp_d [NB][NAE];
  logic [2*ChunkW-1:0] pp_q [NB][NAE];
  logic [AW-1:0]       ev   [NB];
  logic [AW-1:0]       od   [NB];
  logic [RowW-1:0]     row_q [NB];
  logic [SumW-1:0]     sum_d;
  logic [SumW-1:0]     sum_q;
  logic [PW-1:0]       mag;
  logic [PW-1:0]       p_d;
  logic [PW-1:0]       p_q;

  // magnitudes, sign travels alongside
  assign a_abs = a_i[WA-1] ? (~a_i + 1'b1) : a_i;
  assign b_abs = b_i[WB-1] ? (~b_i + 1'b1) : b_i;

  always_ff @(posedge clk_i) begin
    amag_q <= AW'(a_abs);
    bmag_q <= BW'(b_abs);
    neg_q  <= {neg_q[2:0], a_i[WA-1] ^ b_i[WB-1]};
  end

  // digit products
  always_comb begin
    for (int j = 0; j < int'(NB); j++) begin
      for (int i = 0; i < int'(NAE); i++) begin
        pp_d[j][i] = amag_q[i*ChunkW +: ChunkW] * bmag_q[j*ChunkW +: ChunkW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q <= pp_d;
  end

  // even and odd products do not overlap, one add per row
  always_comb begin
    for (int j = 0; j < int'(NB); j++) begin
      for (int k = 0; k < int'(NAE / 2); k++) begin
        ev[j][k*2*ChunkW +: 2*ChunkW] = pp_q[j][2*k];
        od[j][k*2*ChunkW +: 2*ChunkW] = pp_q[j][2*k+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < int'(NB); j++) begin
      row_q[j] <= {{ChunkW{1'b0}}, ev[j]} + {od[j], {ChunkW{1'b0}}};
    end
  end

  // combine rows
  if (NB == 1) begin : g_one_row
    assign sum_d = SumW'(row_q[0]);
  end else begin : g_two_rows
    assign sum_d = {{ChunkW{1'b0}}, row_q[0]} + {row_q[NB-1], {ChunkW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // restore sign
  assign mag = sum_q[PW-1:0];
  assign p_d = neg_q[3] ? (~mag + 1'b1) : mag;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = $signed(p_q);

endmodule

`default_nettype wire

FILE: design/bpc_temp.sv
`default_nettype none

module bpc_temp (
  input  logic                          clk_i,
  input  bpc_pkg::coef_t                coef_i,
  input  logic [23:0]                   raw_temperature_i,
  output logic signed [bpc_pkg::TnW-1:0] tn_o,
  output logic signed [23:0]            temp_o,
  output logic                          clip_o
);
  import bpc_pkg::*;

  localparam int unsigned TqW = TnW - 31;
  localparam logic signed [TnW:0] TRnd = {{(TnW-31){1'b0}}, 1'b1, 31'd0};
  localparam logic signed [TqW-1:0] TqMax = TqW'(TempMax);
  localparam logic signed [TqW-1:0] TqMin = TqW'(TempMin);

  logic signed [24:0]    d_q;
  logic signed [24:0]    d2_q;
  logic signed [41:0]    m1_q;
  logic signed [41:0]    m1b_q;
  logic signed [32:0]    m2_q;
  logic signed [57:0]    m3_q;
  logic signed [TnW-1:0] tn_d;
  logic signed [TnW-1:0] tn_q;
  logic signed [TnW:0]   tr;
  logic signed [TqW-1:0] tq;
  logic signed [23:0]    temp_d;
  logic signed [23:0]    temp_q;
  logic                  clip_d;
  logic                  clip_q;

  // offset from t1, then the two products, then the quadratic term
  always_ff @(posedge clk_i) begin
    d_q   <= $signed({1'b0, raw_temperature_i}) - $signed({1'b0, coef_i.t1});
    m1_q  <= d_q * $signed({1'b0, coef_i.t2});
    m2_q  <= d_q * coef_i.t3;
    d2_q  <= d_q;
    m1b_q <= m1_q;
    m3_q  <= m2_q * d2_q;
    tn_q  <= tn_d;
  end

  assign tn_d = (TnW'(m1b_q) <<< 18) + TnW'(m3_q);

  // round to 1/65536 degC and saturate
  always_comb begin
    tr     = (TnW+1)'(tn_q) + TRnd;
    tq     = tr[TnW:32];
    clip_d = 1'b0;
    temp_d = tq[23:0];
    if (tq > TqMax) begin
      temp_d = TempMax;
      clip_d = 1'b1;
    end else if (tq < TqMin) begin
      temp_d = TempMin;
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    clip_q <= clip_d;
  end

  assign tn_o   = tn_q;
  assign temp_o = temp_q;
  assign clip_o = clip_q;

endmodule

`default_nettype wire

FILE: design/bpc_press.sv
`default_nettype none

// pressure polynomial in Horner form, scaled by 2^181:
//   acc = A<<22 + rp*(B + rp*(C<<85)), rounding half folded into A
module bpc_press (
  input  logic                          clk_i,
  input  bpc_pkg::coef_t                coef_i,
  input  logic signed [bpc_pkg::TnW-1:0] tn_i,
  input  logic [23:0]                   rp_i,
  output logic [25:0]                   press_o,
  output logic                          clip_o
);
  import bpc_pkg::*;

  localparam int unsigned RpW   = 25;
  localparam int unsigned W1    = TnW + 8;
  localparam int unsigned W1S   = W1 + 1;
  localparam int unsigned W2    = W1S + TnW;
  localparam int unsigned W2S   = W2 + 1;
  localparam int unsigned W3    = W2S + TnW;
  localparam int unsigned W3S   = W3 + 1;
  localparam int unsigned C2W   = W1S + RpW;
  localparam int unsigned GW    = C2W + 86;
  localparam int unsigned EW    = W3S + 1;
  localparam int unsigned FW    = EW + RpW;
  localparam int unsigned AccW  = FW + 1;
  localparam int unsigned Frac  = 173;
  localparam int unsigned QW    = AccW - Frac;

  logic signed [W1-1:0]  a1, b1, c1;
  logic signed [W1S-1:0] a1s_q, b1s_q, c1s_q;
  logic signed [W2-1:0]  a2, b2;
  logic signed [W2S-1:0] a2s_q, b2s_q;
  logic signed [W3-1:0]  a3, b3;
  logic signed [W3S-1:0] a3s_q, a3s_dl;
  logic signed [C2W-1:0] c2;
  logic signed [GW-1:0]  g_q, g_dl;
  logic signed [EW-1:0]  e_q;
  logic signed [FW-1:0]  f;
  logic signed [AccW-1:0] acc_q;
  logic signed [32:0]    rpp11_q;
  logic signed [W1S-1:0] k_q, k_dl;
  logic signed [TnW-1:0] tn6, tn12;
  logic [23:0]           rp6, rp18;
  logic [QW-1:0]         q;
  logic [25:0]           press_d, press_q;
  logic                  clip_d, clip_q;

  // operand alignment
  bpc_delay #(.W(TnW), .D(6)) u_tn6  (.clk_i, .d_i(tn_i), .q_o(tn6));
  bpc_delay #(.W(TnW), .D(6)) u_tn12 (.clk_i, .d_i(tn6),  .q_o(tn12));
  bpc_delay #(.W(24),  .D(6)) u_rp6  (.clk_i, .d_i(rp_i), .q_o(rp6));
  bpc_delay #(.W(24),  .D(12)) u_rp18 (.clk_i, .d_i(rp6), .q_o(rp18));

  // constant part of the inner raw pressure term
  always_ff @(posedge clk_i) begin
    rpp11_q <= $signed({1'b0, rp_i}) * coef_i.p11;
    k_q     <= (W1S'(coef_i.p9) <<< 48) + (W1S'(rpp11_q) <<< 31);
  end

  bpc_delay #(.W(W1S), .D(3)) u_k (.clk_i, .d_i(k_q), .q_o(k_dl));

  // first level: coefficient times temperature
  bpc_mul #(.WA(TnW), .WB(8)) u_a1 (.clk_i, .a_i(tn_i), .b_i(coef_i.p8),  .p_o(a1));
  bpc_mul #(.WA(TnW), .WB(8)) u_b1 (.clk_i, .a_i(tn_i), .b_i(coef_i.p4),  .p_o(b1));
  bpc_mul #(.WA(TnW), .WB(8)) u_c1 (.clk_i, .a_i(tn_i), .b_i(coef_i.p10), .p_o(c1));

  always_ff @(posedge clk_i) begin
    a1s_q <= W1S'(a1) + (W1S'(coef_i.p7) <<< 55);
    b1s_q <= W1S'(b1) + (W1S'(coef_i.p3) <<< 53);
    c1s_q <= W1S'(c1) + k_dl;
  end

  // second level
  bpc_mul #(.WA(W1S), .WB(TnW)) u_a2 (.clk_i, .a_i(a1s_q), .b_i(tn6), .p_o(a2));
  bpc_mul #(.WA(W1S), .WB(TnW)) u_b2 (.clk_i, .a_i(b1s_q), .b_i(tn6), .p_o(b2));
  bpc_mul #(.WA(W1S), .WB(RpW)) u_c2 (
    .clk_i, .a_i(c1s_q), .b_i($signed({1'b0, rp6})), .p_o(c2)
  );

  always_ff @(posedge clk_i) begin
    a2s_q <= W2S'(a2) + (W2S'($signed({1'b0, coef_i.p6})) <<< 105);
    b2s_q <= W2S'(b2) + (W2S'(coef_i.p2) <<< 104);
    g_q   <= (GW'(c2) <<< 85) + (GW'(coef_i.p1) <<< 161);
  end

  bpc_delay #(.W(GW), .D(5)) u_g (.clk_i, .d_i(g_q), .q_o(g_dl));

  // third level
  bpc_mul #(.WA(W2S), .WB(TnW)) u_a3 (.clk_i, .a_i(a2s_q), .b_i(tn12), .p_o(a3));
  bpc_mul #(.WA(W2S), .WB(TnW)) u_b3 (.clk_i, .a_i(b2s_q), .b_i(tn12), .p_o(b3));

  // p5 term plus the rounding half, both placed by concatenation
  always_ff @(posedge clk_i) begin
    a3s_q <= W3S'(a3) + $signed(W3S'({coef_i.p5, 12'd1, 150'd0}));
    e_q   <= EW'(b3) + EW'(g_dl);
  end

  bpc_delay #(.W(W3S), .D(5)) u_a3s (.clk_i, .d_i(a3s_q), .q_o(a3s_dl));

  // outer raw pressure multiply
  bpc_mul #(.WA(EW), .WB(RpW)) u_f (
    .clk_i, .a_i(e_q), .b_i($signed({1'b0, rp18})), .p_o(f)
  );

  always_ff @(posedge clk_i) begin
    acc_q <= AccW'(f) + (AccW'(a3s_dl) <<< 22);
  end

  // scale to 1/256 Pa and saturate
  always_comb begin
    q       = acc_q[AccW-1:Frac];
    press_d = q[25:0];
    clip_d  = 1'b0;
    if (q[QW-1]) begin
      press_d = '0;
      clip_d  = 1'b1;
    end else if (|q[QW-2:26]) begin
      press_d = PressMax;
      clip_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    press_q <= press_d;
    clip_q  <= clip_d;
  end

  assign press_o = press_q;
  assign clip_o  = clip_q;

endmodule

`default_nettype wire

FILE: design/barometric_pressure_compensation.sv
// Barometric sensor compensation.
// Input: a raw pressure and temperature pair is transferred at a rising edge
// where start is high and busy is low; busy stays low, so one pair can be
// transferred in every cycle with no gaps.
// Output: done_o marks the compensated result for one cycle. It is driven
// by the last bit of the valid pipeline, and results leave in transfer
// order. The receiver has no back pressure, so nothing is ever held.
// Latency: 4 stages form the linearized temperature, then 25 stages for the
// pressure polynomial: three Horner steps by temperature and one by raw
// pressure, each through a five-stage split multiplier plus an add stage.
// Configuration: cfg_we_i writes calibration word cfg_idx_i at the edge;
// index 3 is ignored. Write only while no item is in flight.
// Reset: clears the calibration words to zero and drops every item in
// flight; no result appears for them.
`default_nettype none

module barometric_pressure_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic [23:0]        raw_pressure_i,
  input  logic [23:0]        raw_temperature_i,
  output logic               done_o,
  output logic signed [23:0] temperature_out_o,
  output logic [25:0]        pressure_out_o,
  output logic               clipped_o
);
  import bpc_pkg::*;

  logic [CfgW-1:0]     cal_low_q;
  logic [CfgW-1:0]     cal_mid_q;
  logic [CalHighW-1:0] cal_high_q;
  coef_t               coef;
  logic [TotalLat-1:0] vld_q;
  logic [23:0]         rp_al;
  logic signed [TnW-1:0] tn;
  logic signed [23:0]  temp;
  logic                tclip;
  logic [24:0]         temp_dl;
  logic [25:0]         press;
  logic                pclip;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= '0;
      cal_mid_q  <= '0;
      cal_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW:  cal_low_q  <= cfg_wdata_i;
        CFG_MID:  cal_mid_q  <= cfg_wdata_i;
        CFG_HIGH: cal_high_q <= cfg_wdata_i[CalHighW-1:0];
        default:  ;
      endcase
    end
  end

  assign coef = bpc_decode({cal_high_q, cal_mid_q, cal_low_q});

  // always ready, one transfer per cycle
  assign busy = 1'b0;

  // valid bits travel with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TotalLat-2:0], start & ~busy};
    end
  end

  bpc_temp u_temp (
    .clk_i,
    .coef_i            (coef),
    .raw_temperature_i (raw_temperature_i),
    .tn_o              (tn),
    .temp_o            (temp),
    .clip_o            (tclip)
  );

  bpc_delay #(.W(24), .D(TnLat)) u_rp_dl (
    .clk_i, .d_i(raw_pressure_i), .q_o(rp_al)
  );

  bpc_press u_press (
    .clk_i,
    .coef_i  (coef),
    .tn_i    (tn),
    .rp_i    (rp_al),
    .press_o (press),
    .clip_o  (pclip)
  );

  // temperature result waits for the pressure result
  bpc_delay #(.W(25), .D(PressLat - 1)) u_temp_dl (
    .clk_i, .d_i({tclip, temp}), .q_o(temp_dl)
  );

  assign done_o            = vld_q[TotalLat-1];
  assign temperature_out_o = $signed(temp_dl[23:0]);
  assign pressure_out_o    = press;
  assign clipped_o         = temp_dl[24] | pclip;

endmodule

`default_nettype wire

FILE: design/bpc_checker.sv
`default_nettype none

module bpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [23:0] temperature_out_o,
  input logic [25:0]        pressure_out_o,
  input logic               clipped_o
);
  import bpc_pkg::*;

  // every result comes from a transfer a fixed latency earlier
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, TotalLat))
    else $error("result without a matching transfer");

  // a transfer always yields a result after the fixed latency
  a_start_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##TotalLat (done_o || !$past(rst_ni, 1)))
    else $error("transfer without a result");

  // the pipeline never refuses a transfer
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // a clip flag needs a value at a range limit
  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && temperature_out_o != TempMax && temperature_out_o != TempMin
     && pressure_out_o != '0 && pressure_out_o != PressMax) |-> !clipped_o)
    else $error("clip flag without saturated result");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);

`default_nettype wire

FILE: dv/barometric_pressure_compensation_test.sv
`timescale 1ns / 100ps

module barometric_pressure_compensation_test;
  import bpc_pkg::*;

  localparam int unsigned NumRandom = 1700;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainWait = TotalLat + 10;
  localparam logic [1:0]  CfgUnused = 2'd3;

  typedef struct {
    logic signed [23:0] temp;
    logic [25:0]        press;
    logic               clip;
  } reading_t;

  typedef struct {
    int          cal;
    logic [23:0] rp;
    logic [23:0] rt;
    bit          typed;
    reading_t    want;
  } row_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] mid;
    logic [39:0] hi;
  } cal_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [63:0]        cfg_wdata_i;
  logic [23:0]        raw_pressure_i;
  logic [23:0]        raw_temperature_i;
  logic               done_o;
  logic signed [23:0] temperature_out_o;
  logic [25:0]        pressure_out_o;
  logic               clipped_o;

  // calibration as the block currently holds it
  logic [63:0] cal_lo, cal_mid;
  logic [39:0] cal_hi;

  reading_t pending_q[$];
  reading_t typed_want;
  bit       typed_valid;
  int       mismatches, n_xfer, n_done, n_clip, idle_cycles;

  barometric_pressure_compensation DUT (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic signed [255:0] wide(input longint v);
    wide = v;
  endfunction

  // exact compensation: temperature at 2^48, pressure at 2^181
  function automatic reading_t compensate(input logic [23:0] rp, input logic [23:0] rt);
    logic [167:0] cb;
    logic [7:0] b[21];
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11, d, tn, tr;
    logic signed [255:0] x, x2, x3, r, r2, acc;
    reading_t res;
    cb = {cal_hi, cal_mid, cal_lo};
    for (int k = 0; k < 21; k++) b[k] = cb[8*k +: 8];
    t1  = longint'({b[1], b[0]}) * 256;
    t2  = longint'({b[3], b[2]});
    t3  = longint'($signed(b[4]));
    p1  = longint'($signed({b[6], b[5]})) - 16384;
    p2  = longint'($signed({b[8], b[7]})) - 16384;
    p3  = longint'($signed(b[9]));
    p4  = longint'($signed(b[10]));
    p5  = longint'({b[12], b[11]});
    p6  = longint'({b[14], b[13]});
    p7  = longint'($signed(b[15]));
    p8  = longint'($signed(b[16]));
    p9  = longint'($signed({b[18], b[17]}));
    p10 = longint'($signed(b[19]));
    p11 = longint'($signed(b[20]));
    d  = longint'(rt) - t1;
    tn = d * t2 * 262144 + d * d * t3;
    tr = (tn + 64'sh80000000) >>> 32;
    res.clip = 1'b0;
    if (tr > 8388607) begin
      tr = 8388607;
      res.clip = 1'b1;
    end else if (tr < -8388608) begin
      tr = -8388608;
      res.clip = 1'b1;
    end
    res.temp = tr[23:0];
    x  = wide(tn);
    x2 = x * x;
    x3 = x2 * x;
    r  = wide(longint'(rp));
    r2 = r * r;
    acc = (wide(p5) <<< 184) + ((x * wide(p6)) <<< 127) + ((x2 * wide(p7)) <<< 77)
        + ((x3 * wide(p8)) <<< 22) + ((r * wide(p1)) <<< 161)
        + ((x * r * wide(p2)) <<< 104) + ((x2 * r * wide(p3)) <<< 53)
        + (x3 * r * wide(p4)) + ((r2 * wide(p9)) <<< 133)
        + ((x * r2 * wide(p10)) <<< 85) + ((r2 * r * wide(p11)) <<< 116)
        + (wide(1) <<< 172);
    if (acc[255]) begin
      res.press = '0;
      res.clip  = 1'b1;
    end else if (|acc[254:199]) begin
      res.press = PressMax;
      res.clip  = 1'b1;
    end else begin
      res.press = acc[198:173];
    end
    return res;
  endfunction

  // transfers, results and watchdog, all sampled mid cycle
  always @(negedge clk_i) begin
    reading_t w;
    if (rst_ni) begin
      idle_cycles++;
      if (start && !busy) begin
        pending_q.push_back(typed_valid ? typed_want
                                        : compensate(raw_pressure_i, raw_temperature_i));
        n_xfer++;
        idle_cycles = 0;
      end
      if (done_o) begin
        idle_cycles = 0;
        n_done++;
        if (clipped_o) n_clip++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result t=%0d p=%0d c=%0b",
                                         temperature_out_o, pressure_out_o, clipped_o);
        end else begin
          w = pending_q.pop_front();
          if (w.temp !== temperature_out_o || w.press !== pressure_out_o ||
              w.clip !== clipped_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want t=%0d p=%0d c=%0b got t=%0d p=%0d c=%0b",
                       w.temp, w.press, w.clip,
                       temperature_out_o, pressure_out_o, clipped_o);
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired with %0d results pending", pending_q.size());
        $display("[barometric_pressure_compensation] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // let everything in flight drain before touching calibration
  task automatic drain();
    @(posedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic load_cal(input cal_t c);
    drain();
    write_reg(CFG_LOW, c.lo);
    write_reg(CFG_MID, c.mid);
    write_reg(CFG_HIGH, {24'hA5A5A5, c.hi});
    write_reg(CfgUnused, 64'hDEAD_BEEF_0123_4567);
    cal_lo  = c.lo;
    cal_mid = c.mid;
    cal_hi  = c.hi;
  endtask

  // one transfer, with random gaps ahead of it
  task automatic send(input logic [23:0] rp, input logic [23:0] rt, input int gap_pct,
                      input bit typed, input reading_t want);
    bit taken;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start             <= 1'b1;
    raw_pressure_i    <= rp;
    raw_temperature_i <= rt;
    typed_valid       <= typed;
    typed_want        <= want;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
  endtask

  cal_t cals[6];
  row_t rows[$];

  function automatic row_t mk(input int c, input logic [23:0] rp, input logic [23:0] rt,
                              input bit typed, input logic signed [23:0] t,
                              input logic [25:0] p, input logic cl);
    row_t r;
    r.cal = c;
    r.rp = rp;
    r.rt = rt;
    r.typed = typed;
    r.want.temp = t;
    r.want.press = p;
    r.want.clip = cl;
    return r;
  endfunction

  initial begin
    int cur, gap_pct;
    logic [23:0] rp, rt, t1v;
    reading_t none;
    none = '{temp: '0, press: '0, clip: 1'b0};
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LOW;
    cfg_wdata_i = '0;
    raw_pressure_i = '0;
    raw_temperature_i = '0;
    typed_valid = 1'b0;
    typed_want = none;
    cal_lo = '0;
    cal_mid = '0;
    cal_hi = '0;
    mismatches = 0;
    n_xfer = 0;
    n_done = 0;
    n_clip = 0;
    idle_cycles = 0;

    // calibration sets: reset zeros, typical sensor, temperature rails,
    // pressure rail, all ones, and a random one drawn again in the random part
    cals[0] = '{lo: '0, mid: '0, hi: '0};
    cals[1] = '{lo: 64'h200A_D0F9_7100_6B00, mid: 64'h0374_A543_6C01_FD05,
                hi: 40'hEC_073B_C8F6};
    cals[2] = '{lo: 64'h0000_0000_FFFF_FFFF, mid: '0, hi: '0};
    cals[3] = '{lo: 64'h0040_0000_0000_0000, mid: 64'h0000_00FF_FF00_0000, hi: '0};
    cals[4] = '{lo: '1, mid: '1, hi: '1};
    cals[5] = '{lo: {$urandom, $urandom}, mid: {$urandom, $urandom},
                hi: 40'({$urandom, $urandom})};

    // directed rows, typed where the answer is obvious
    rows.push_back(mk(0, 24'h000000, 24'h000000, 1'b1, 24'sd0, 26'd0, 1'b0));
    rows.push_back(mk(0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'sd0, 26'd0, 1'b1));
    rows.push_back(mk(0, 24'h000001, 24'h800000, 1'b1, 24'sd0, 26'd0, 1'b1));
    rows.push_back(mk(1, 24'h000000, 24'h000000, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(1, 24'h6B0000, 24'h6B0000, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(1, 24'h5A3C10, 24'h7F1234, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(1, 24'h800000, 24'h555555, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(1, 24'h7FFFFF, 24'hAAAAAA, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(2, 24'h000000, 24'h000000, 1'b1, TempMin, 26'd0, 1'b1));
    rows.push_back(mk(2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(2, 24'h123456, 24'hFFFF00, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(3, 24'h000000, 24'h000000, 1'b1, 24'sd0, PressMax, 1'b1));
    rows.push_back(mk(3, 24'hFFFFFF, 24'h000000, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(4, 24'h000000, 24'h000000, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(4, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0, 1'b0));
    rows.push_back(mk(4, 24'hFFFF00, 24'hFFFF00, 1'b0, '0, '0, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].cal != cur) begin
        cur = rows[i].cal;
        load_cal(cals[cur]);
      end
      send(rows[i].rp, rows[i].rt, 0, rows[i].typed, rows[i].want);
    end

    // random part: calibration rotates, sender gaps by phase
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 5) cals[5] = '{lo: {$urandom, $urandom}, mid: {$urandom, $urandom},
                               hi: 40'({$urandom, $urandom})};
      cur = (ph == 0 || ph == 6) ? 1 : (ph % 6);
      load_cal(cals[cur]);
      t1v = {cals[cur].lo[15:0], 8'h00};
      gap_pct = (ph < 3) ? 8 : (ph < 6) ? 80 : 0;
      for (int n = 0; n < NumRandom / 10; n++) begin
        rp = 24'($urandom);
        // mostly near the calibration point, some anywhere
        if ($urandom_range(3) != 0) rt = t1v + 24'($signed(17'($urandom)));
        else rt = 24'($urandom);
        send(rp, rt, gap_pct, 1'b0, none);
        if (n == 50) drain();
      end
    end

    drain();
    $display("%0d transfers, %0d results (%0d saturated) over six calibration sets",
             n_xfer, n_done, n_clip);
    $display("%0d mismatches, %0d results still expected", mismatches, pending_q.size());
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("[barometric_pressure_compensation] OK");
    end else begin
      $display("[barometric_pressure_compensation] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/bpc_pkg.sv
design/bpc_delay.sv
design/bpc_mul.sv
design/bpc_temp.sv
design/bpc_press.sv
design/barometric_pressure_compensation.sv
design/bpc_checker.sv
dv/barometric_pressure_compensation_test.sv
